// ===== design/assert_macros.svh =====
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BZ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BZ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define BZ_ASSERT(lbl, prop, msg)
`define BZ_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== design/bzrg_pkg.sv =====
// types and constants of the reaction grid stepper
`default_nettype none
package bzrg_pkg;

    localparam int GRID_WIDTH_DEF  = 32;
    localparam int GRID_HEIGHT_DEF = 32;

    localparam logic [8:0] BIAS_RESET = 9'd259;

    // floor(s / 9) == (s * 3641) >> 15 for every s below 2^15
    localparam int          MUL_W      = 12;
    localparam int          PROD_W     = 2 * MUL_W;
    localparam logic [11:0] DIV9_RECIP = 12'd3641;
    localparam int          DIV9_SHIFT = 15;

    localparam logic [3:0] NBR_COUNT = 4'd9;
    localparam logic [2:0] OP_LAST   = 3'd5;
    localparam logic [2:0] OP_DIV_C  = 3'd2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef struct packed {
        logic       func;
        logic [4:0] cell_x;
        logic [4:0] cell_y;
        logic [7:0] value_a;
        logic [7:0] value_b;
        logic [7:0] value_c;
    } in_t;

    typedef struct packed {
        logic [4:0] pixel_x;
        logic [4:0] pixel_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       generation_end;
    } out_t;

    typedef struct packed {
        logic [7:0] c;
        logic [7:0] b;
        logic [7:0] a;
    } cell_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_MATH  = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

endpackage
`default_nettype wire

// ===== design/bzrg_cell_mem.sv =====
// single-port cell memory holding both grid banks, registered read
`default_nettype none
module bzrg_cell_mem #(
    parameter int ADDR_W = 11
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_W-1:0]    addr,
    input  wire bzrg_pkg::cell_t      wdata,
    output bzrg_pkg::cell_t           rdata
);
    import bzrg_pkg::*;

    cell_t mem [2**ADDR_W];
    cell_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== design/bzrg_mul_unit.sv =====
// shared unsigned multiplier with registered product
`default_nettype none
module bzrg_mul_unit (
    input  wire logic                          clk,
    input  wire logic [bzrg_pkg::MUL_W-1:0]    op_a,
    input  wire logic [bzrg_pkg::MUL_W-1:0]    op_b,
    output logic [bzrg_pkg::PROD_W-1:0]        product
);
    import bzrg_pkg::*;

    logic [PROD_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign product = product_reg;

endmodule
`default_nettype wire

// ===== design/bz_reaction_grid_step.sv =====
// top level: reaction grid stepper with sequencer around the shared multiplier
//
// A toroidal grid of three-channel cells lives in one single-port memory that
// holds two banks. Input beats on in_valid/in_ready carry either a load (one
// in-range cell written into the active bank, no result) or a step (the next cell in
// raster order is computed into the other bank, one result beat).
// A load is written in the cycle its beat is taken. A step holds in_ready low
// through nine neighbour reads through the registered memory port, the
// shared multiplier (three divides by nine and three reaction products)
// and the write-back. No new beat is taken before a step is written back;
// the memory port and the single multiplier keep steps serial.
// Results leave through an output register on out_valid/out_ready; generation
// end is flagged on the last cell, when the banks swap. While the receiver
// stalls, loads are still taken; a finished step waits in write-back until
// the output register is free.
// The reaction bias is written on cfg_valid/cfg_ready, always ready.
// Reset returns the scan to cell zero, bank zero and the bias to 259; the
// memory content is undefined until loaded.
`default_nettype none
module bz_reaction_grid_step #(
    parameter int GRID_WIDTH  = bzrg_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = bzrg_pkg::GRID_HEIGHT_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire bzrg_pkg::in_t   in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output bzrg_pkg::out_t       out_data,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [8:0]      cfg_data
);
    import bzrg_pkg::*;
`include "assert_macros.svh"

    localparam int XW     = $clog2(GRID_WIDTH);
    localparam int YW     = $clog2(GRID_HEIGHT);
    localparam int ADDR_W = 1 + XW + YW;
    localparam logic [XW-1:0] X_MAX = XW'(GRID_WIDTH - 1);
    localparam logic [YW-1:0] Y_MAX = YW'(GRID_HEIGHT - 1);

    state_t state_reg, state_next;

    logic [8:0]    bias_reg;
    logic          bank_reg;
    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic [XW-1:0] xm1_reg;
    logic [XW-1:0] nx_reg;
    logic [YW-1:0] ny_reg;
    logic [1:0]    col_cnt_reg;
    logic [3:0]    rd_cnt_reg;
    logic [11:0]   sum_a_reg, sum_b_reg, sum_c_reg;
    logic [7:0]    avg_a_reg, avg_b_reg, avg_c_reg;
    logic [7:0]    new_a_reg, new_b_reg, new_c_reg;
    logic [2:0]    op_reg;
    logic          phase_reg;
    logic          pos_reg;
    logic          out_valid_reg;
    out_t          out_data_reg;

    logic              in_fire, load_fire, step_fire, ld_in_range, out_load, last_cell;
    logic [8:0]        ld_x_wide, ld_y_wide, x_wide, y_wide;
    logic [XW-1:0]     xm1;
    logic [YW-1:0]     ym1;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    cell_t             mem_wdata, mem_rdata;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] product;
    logic [7:0]        r_s, r_p, r_q;
    logic signed [10:0] factor;
    logic [9:0]        react_r;
    logic [7:0]        math_res;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign load_fire = in_fire && (in_data.func == FUNC_LOAD);
    assign step_fire = in_fire && (in_data.func == FUNC_STEP);

    assign ld_x_wide   = 9'(in_data.cell_x);
    assign ld_y_wide   = 9'(in_data.cell_y);
    assign ld_in_range = (ld_x_wide < 9'(GRID_WIDTH)) && (ld_y_wide < 9'(GRID_HEIGHT));

    assign xm1 = (x_reg == '0) ? X_MAX : x_reg - 1'b1;
    assign ym1 = (y_reg == '0) ? Y_MAX : y_reg - 1'b1;

    assign last_cell = (x_reg == X_MAX) && (y_reg == Y_MAX);
    assign out_load  = (state_reg == ST_WRITE) && (!out_valid_reg || out_ready);

    // memory port shared by loads, neighbour reads and write-back
    always_comb
    begin
        mem_addr  = {bank_reg, ny_reg, nx_reg};
        mem_we    = 1'b0;
        mem_wdata = '{c: new_c_reg, b: new_b_reg, a: new_a_reg};
        if (state_reg == ST_IDLE)
        begin
            mem_addr  = {bank_reg, ld_y_wide[YW-1:0], ld_x_wide[XW-1:0]};
            mem_we    = load_fire && ld_in_range;
            mem_wdata = '{c: in_data.value_c, b: in_data.value_b, a: in_data.value_a};
        end
        else if (state_reg == ST_WRITE)
        begin
            mem_addr = {~bank_reg, y_reg, x_reg};
            mem_we   = 1'b1;
        end
    end

    bzrg_cell_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // operand selection: ops 0-2 divide sums by nine, ops 3-5 react
    always_comb
    begin
        r_s = avg_a_reg;
        r_p = avg_b_reg;
        r_q = avg_c_reg;
        mul_a = sum_a_reg;
        case (op_reg)
            3'd1:    mul_a = sum_b_reg;
            3'd2:    mul_a = sum_c_reg;
            default: mul_a = sum_a_reg;
        endcase
        case (op_reg)
            3'd4:
            begin
                r_s = avg_b_reg;
                r_p = avg_c_reg;
                r_q = avg_a_reg;
            end
            3'd5:
            begin
                r_s = avg_c_reg;
                r_p = avg_a_reg;
                r_q = avg_b_reg;
            end
            default:
            begin
                r_s = avg_a_reg;
                r_p = avg_b_reg;
                r_q = avg_c_reg;
            end
        endcase
        factor = $signed(11'(bias_reg)) + $signed(11'(r_p)) - $signed(11'(r_q));
        mul_b  = DIV9_RECIP;
        if (op_reg > OP_DIV_C)
        begin
            mul_a = MUL_W'(r_s);
            mul_b = MUL_W'(factor[9:0]);
        end
    end

    bzrg_mul_unit u_mul (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    assign react_r = product[17:8];

    always_comb
    begin
        if (op_reg <= OP_DIV_C)
        begin
            math_res = product[DIV9_SHIFT+7:DIV9_SHIFT];
        end
        else if (!pos_reg)
        begin
            math_res = 8'd0;
        end
        else if (react_r > 10'd255)
        begin
            math_res = 8'd255;
        end
        else
        begin
            math_res = react_r[7:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (step_fire)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (rd_cnt_reg == NBR_COUNT)
                begin
                    state_next = ST_MATH;
                end
            end
            ST_MATH:
            begin
                if (phase_reg && (op_reg == OP_LAST))
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bias_reg      <= BIAS_RESET;
            bank_reg      <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            out_valid_reg <= 1'b0;
            rd_cnt_reg    <= '0;
            col_cnt_reg   <= '0;
            op_reg        <= '0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                bias_reg <= cfg_data;
            end
            if (step_fire)
            begin
                rd_cnt_reg  <= '0;
                col_cnt_reg <= '0;
                op_reg      <= '0;
                phase_reg   <= 1'b0;
            end
            if ((state_reg == ST_READ) && (rd_cnt_reg != NBR_COUNT))
            begin
                rd_cnt_reg  <= rd_cnt_reg + 4'd1;
                col_cnt_reg <= (col_cnt_reg == 2'd2) ? 2'd0 : col_cnt_reg + 2'd1;
            end
            if (state_reg == ST_MATH)
            begin
                phase_reg <= ~phase_reg;
                if (phase_reg && (op_reg != OP_LAST))
                begin
                    op_reg <= op_reg + 3'd1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                if (last_cell)
                begin
                    x_reg    <= '0;
                    y_reg    <= '0;
                    bank_reg <= ~bank_reg;
                end
                else if (x_reg == X_MAX)
                begin
                    x_reg <= '0;
                    y_reg <= y_reg + 1'b1;
                end
                else
                begin
                    x_reg <= x_reg + 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            xm1_reg   <= xm1;
            nx_reg    <= xm1;
            ny_reg    <= ym1;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            sum_c_reg <= '0;
        end
        if (state_reg == ST_READ)
        begin
            if (rd_cnt_reg != NBR_COUNT)
            begin
                // walk the 3x3 window, wrapping at the grid edges
                if (col_cnt_reg == 2'd2)
                begin
                    nx_reg <= xm1_reg;
                    ny_reg <= (ny_reg == Y_MAX) ? '0 : ny_reg + 1'b1;
                end
                else
                begin
                    nx_reg <= (nx_reg == X_MAX) ? '0 : nx_reg + 1'b1;
                end
            end
            if (rd_cnt_reg != '0)
            begin
                sum_a_reg <= sum_a_reg + 12'(mem_rdata.a);
                sum_b_reg <= sum_b_reg + 12'(mem_rdata.b);
                sum_c_reg <= sum_c_reg + 12'(mem_rdata.c);
            end
        end
        if ((state_reg == ST_MATH) && !phase_reg)
        begin
            pos_reg <= (factor > 11'sd0);
        end
        if ((state_reg == ST_MATH) && phase_reg)
        begin
            case (op_reg)
                3'd0:    avg_a_reg <= math_res;
                3'd1:    avg_b_reg <= math_res;
                3'd2:    avg_c_reg <= math_res;
                3'd3:    new_a_reg <= math_res;
                3'd4:    new_b_reg <= math_res;
                default: new_c_reg <= math_res;
            endcase
        end
        if (out_load)
        begin
            out_data_reg.pixel_x        <= x_wide[4:0];
            out_data_reg.pixel_y        <= y_wide[4:0];
            out_data_reg.red            <= new_a_reg;
            out_data_reg.green          <= new_b_reg;
            out_data_reg.blue           <= new_c_reg;
            out_data_reg.generation_end <= last_cell;
        end
    end

    assign x_wide    = 9'(x_reg);
    assign y_wide    = 9'(y_reg);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `BZ_ASSERT_IMPL(a_step_busy, $past(step_fire), !in_ready, "ready high after a step beat")
    `BZ_ASSERT_IMPL(a_bank_swap, $changed(bank_reg), $past(out_load && last_cell), "bad swap")
    `BZ_ASSERT_IMPL(a_out_src, $rose(out_valid_reg), $past(state_reg == ST_WRITE), "stray result")
    `BZ_ASSERT(a_scan_range, (x_reg <= X_MAX) && (y_reg <= Y_MAX), "scan position left the grid")

endmodule
`default_nettype wire

// ===== tb/sv/tb_bz_reaction_grid_step.sv =====
// self-checking testbench of the reaction grid stepper
`timescale 1ns / 100ps
module tb_bz_reaction_grid_step;
    import bzrg_pkg::*;

    localparam int GW              = GRID_WIDTH_DEF;
    localparam int GH              = GRID_HEIGHT_DEF;
    localparam int CELLS           = GW * GH;
    localparam int PHASES          = 6;
    localparam int STEPS_PER_PHASE = 53;
    localparam int SETTLE_CYCLES   = 40;
    localparam int CALM_TAIL       = 150;
    localparam int HOLD_AT         = 400;
    localparam int LONG_HOLD       = 300;
    localparam int STALL_LIMIT     = 3000;
    localparam int END_SETTLE      = 60;
    localparam int MAX_REPORTS     = 10;

    typedef enum logic [1:0] {
        KIND_ITEM,
        KIND_BIAS,
        KIND_DRAIN
    } beat_kind_t;

    typedef struct {
        beat_kind_t kind;
        in_t        item;
        logic [8:0] bias;
    } beat_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    in_t        in_data   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [8:0] cfg_data  = '0;
    wire        in_ready;
    wire        out_valid;
    out_t       out_data;
    wire        cfg_ready;

    // stimulus still to be offered
    beat_t beat_q[$];

    // stimulus planning: tracks which cells are written so no step reads a hole
    int  plan_scan = 0;
    bit  plan_bank = 1'b0;
    bit  plan_written [2][CELLS];

    // predicted state of the grid
    cell_t      grid_mem [2][CELLS];
    int         scan_now = 0;
    bit         bank_now = 1'b0;
    logic [8:0] bias_now = BIAS_RESET;
    out_t       pixels_due[$];

    int   mismatch_cnt = 0;
    int   taken_cnt    = 0;
    logic calm         = 1'b0;
    int   gap_left     = 0;
    int   settle       = 0;
    int   stall_left   = 0;
    int   long_hold    = 0;
    bit   hold_done    = 1'b0;
    int   quiet_cycles = 0;

    bz_reaction_grid_step i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [7:0] rand_conc();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] react_channel(input int s, input int p, input int q);
        int factor;
        int r;
        factor = int'(bias_now) + p - q;
        // a drive of zero or below kills the channel
        if (factor <= 0)
            return 8'd0;
        r = (s * factor) >>> 8;
        if (r > 255)
            r = 255;
        return r[7:0];
    endfunction

    task automatic advance_grid(input in_t it);
        int    sa, sb, sc, cx, cy, k, j, nx, ny;
        cell_t nbr;
        out_t  px;
        if (it.func == FUNC_LOAD) begin
            if (it.cell_x < GW && it.cell_y < GH)
                grid_mem[bank_now][it.cell_y * GW + it.cell_x] =
                    {it.value_c, it.value_b, it.value_a};
        end
        else begin
            cx = scan_now % GW;
            cy = scan_now / GW;
            sa = 0;
            sb = 0;
            sc = 0;
            for (k = 0; k < 3; k++)
                for (j = 0; j < 3; j++)
                begin
                    ny  = (cy + GH - 1 + k) % GH;
                    nx  = (cx + GW - 1 + j) % GW;
                    nbr = grid_mem[bank_now][ny * GW + nx];
                    sa += nbr.a;
                    sb += nbr.b;
                    sc += nbr.c;
                end
            sa = sa / 9;
            sb = sb / 9;
            sc = sc / 9;
            px.pixel_x        = 5'(cx);
            px.pixel_y        = 5'(cy);
            px.red            = react_channel(sa, sb, sc);
            px.green          = react_channel(sb, sc, sa);
            px.blue           = react_channel(sc, sa, sb);
            px.generation_end = (scan_now == CELLS - 1);
            grid_mem[bank_now ^ 1][scan_now] = {px.blue, px.green, px.red};
            if (px.generation_end) begin
                scan_now = 0;
                bank_now = ~bank_now;
            end
            else
                scan_now++;
            pixels_due.push_back(px);
        end
    endtask

    task automatic check_pixel(input out_t got);
        out_t  want;
        string bad;
        bad = "";
        if (pixels_due.size() == 0) begin
            want = 'x;
            bad  = " (nothing pending)";
        end
        else begin
            want = pixels_due.pop_front();
            if (got.pixel_x !== want.pixel_x)
                bad = {bad, " pixel_x"};
            if (got.pixel_y !== want.pixel_y)
                bad = {bad, " pixel_y"};
            if (got.red !== want.red)
                bad = {bad, " red"};
            if (got.green !== want.green)
                bad = {bad, " green"};
            if (got.blue !== want.blue)
                bad = {bad, " blue"};
            if (got.generation_end !== want.generation_end)
                bad = {bad, " generation_end"};
        end
        if (bad != "") begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
                $display("mismatch%s: want (%0d,%0d) %0d/%0d/%0d %b got (%0d,%0d) %0d/%0d/%0d %b",
                         bad, want.pixel_x, want.pixel_y, want.red, want.green, want.blue,
                         want.generation_end, got.pixel_x, got.pixel_y, got.red, got.green,
                         got.blue, got.generation_end);
        end
    endtask

    task automatic queue_item(input in_t it);
        beat_t cmd;
        cmd.kind = KIND_ITEM;
        cmd.item = it;
        cmd.bias = '0;
        beat_q.push_back(cmd);
    endtask

    task automatic push_load(input logic [4:0] x, input logic [4:0] y,
                             input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        in_t it;
        it.func    = FUNC_LOAD;
        it.cell_x  = x;
        it.cell_y  = y;
        it.value_a = a;
        it.value_b = b;
        it.value_c = c;
        queue_item(it);
        plan_written[plan_bank][y * GW + x] = 1'b1;
    endtask

    task automatic push_step();
        int  cx, cy, k, j, nx, ny;
        in_t it;
        cx = plan_scan % GW;
        cy = plan_scan / GW;
        // fill holes in the neighbourhood first
        for (k = 0; k < 3; k++)
            for (j = 0; j < 3; j++)
            begin
                ny = (cy + GH - 1 + k) % GH;
                nx = (cx + GW - 1 + j) % GW;
                if (!plan_written[plan_bank][ny * GW + nx])
                    push_load(5'(nx), 5'(ny), rand_conc(), rand_conc(), rand_conc());
            end
        // cell and value fields are don't-care on a step
        it.func    = FUNC_STEP;
        it.cell_x  = 5'($urandom_range(0, 31));
        it.cell_y  = 5'($urandom_range(0, 31));
        it.value_a = 8'($urandom_range(0, 255));
        it.value_b = 8'($urandom_range(0, 255));
        it.value_c = 8'($urandom_range(0, 255));
        queue_item(it);
        plan_written[plan_bank ^ 1][plan_scan] = 1'b1;
        if (plan_scan == CELLS - 1) begin
            plan_scan = 0;
            plan_bank = ~plan_bank;
        end
        else
            plan_scan++;
    endtask

    // sender: offers queued beats, predicts on every accepted item
    always @(posedge clk)
    begin : sender
        logic  in_fire, cfg_fire, nv, ncv;
        beat_t head;
        if (rst_n) begin
            in_fire  = in_valid && in_ready;
            cfg_fire = cfg_valid && cfg_ready;
            if (in_fire) begin
                advance_grid(in_data);
                taken_cnt <= taken_cnt + 1;
            end
            if (cfg_fire)
                bias_now = cfg_data;
            nv  = in_valid && !in_fire;
            ncv = cfg_valid && !cfg_fire;
            if (!nv && !ncv && beat_q.size() != 0) begin
                head = beat_q[0];
                if (gap_left != 0)
                    gap_left--;
                else if (head.kind == KIND_DRAIN) begin
                    // all pixels back, then let a trailing load finish
                    if (pixels_due.size() != 0)
                        settle = 0;
                    else if (settle == SETTLE_CYCLES) begin
                        settle = 0;
                        void'(beat_q.pop_front());
                    end
                    else
                        settle++;
                end
                else if (head.kind == KIND_BIAS) begin
                    ncv = 1'b1;
                    cfg_data <= head.bias;
                    void'(beat_q.pop_front());
                end
                else if (!calm && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(0, 5);
                else begin
                    nv = 1'b1;
                    in_data <= head.item;
                    void'(beat_q.pop_front());
                end
            end
            in_valid  <= nv;
            cfg_valid <= ncv;
            calm      <= (beat_q.size() < CALM_TAIL);
        end
    end

    // receiver: checks pixel beats and throttles out_ready
    always @(posedge clk)
    begin : receiver
        logic rdy;
        if (rst_n) begin
            if (out_valid && out_ready)
                check_pixel(out_data);
            rdy = 1'b1;
            if (long_hold != 0) begin
                long_hold--;
                rdy = 1'b0;
            end
            else if (!hold_done && taken_cnt >= HOLD_AT) begin
                // long back-pressure so the block backs up into its input
                hold_done = 1'b1;
                long_hold = LONG_HOLD - 1;
                rdy       = 1'b0;
            end
            else if (stall_left != 0) begin
                stall_left--;
                rdy = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 5);
                rdy        = 1'b0;
            end
            out_ready <= rdy;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int         k, j, ph, steps;
        logic [8:0] pick;
        beat_t      cmd;

        // full-scale neighbourhood around cell 0: every channel saturates
        for (k = 0; k < 3; k++)
            for (j = 0; j < 3; j++)
                push_load(5'((GW - 1 + j) % GW), 5'((GH - 1 + k) % GH),
                          8'd255, 8'd255, 8'd255);
        push_step();
        // empty column next to cell 1
        for (k = 0; k < 3; k++)
            push_load(5'd2, 5'((GH - 1 + k) % GH), 8'd0, 8'd0, 8'd0);
        // rewrite mid-generation, seen by the following steps
        push_load(5'd1, 5'd0, 8'd0, 8'd255, 8'd0);
        push_step();
        push_step();

        cmd.item = '0;
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       pick = 9'd0;
                1:       pick = 9'd511;
                2:       pick = 9'd1;
                3:       pick = BIAS_RESET;
                default: pick = 9'($urandom_range(0, 511));
            endcase
            cmd.kind = KIND_DRAIN;
            cmd.bias = '0;
            beat_q.push_back(cmd);
            cmd.kind = KIND_BIAS;
            cmd.bias = pick;
            beat_q.push_back(cmd);
            steps = 0;
            while (steps < STEPS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 15)
                    push_load(5'($urandom_range(0, GW - 1)), 5'($urandom_range(0, GH - 1)),
                              rand_conc(), rand_conc(), rand_conc());
                else begin
                    push_step();
                    steps++;
                end
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (beat_q.size() != 0 || in_valid || cfg_valid || pixels_due.size() != 0)
            @(posedge clk);
        repeat (END_SETTLE) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/bzrg_pkg.sv
design/bzrg_cell_mem.sv
design/bzrg_mul_unit.sv
design/bz_reaction_grid_step.sv
tb/sv/tb_bz_reaction_grid_step.sv
